[src/uart_baud_divisor_calc_core_assert.svh]
// Assertion macros for the baud divisor calculator RTL.
`ifndef UART_BAUD_DIVISOR_CALC_CORE_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_CORE_ASSERT_SVH

// Implication checked outside reset.
`define UBDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ubdc check failed");

// Implication checked at every edge, reset included.
`define UBDC_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error("ubdc check failed");

`endif

[src/ubdc_pkg.sv]
// Types and constants for the baud divisor calculator.
package ubdc_pkg;
    localparam int unsigned NumBits  = 32;
    localparam int unsigned DenBits  = 36;
    localparam int unsigned HundBits = 7;
    localparam int unsigned QuotBits = NumBits + HundBits;
    localparam int unsigned FracBits = 4;
    localparam int unsigned WordBits = 16;

    typedef struct packed {
        logic [DenBits-1:0]  rem;
        logic [NumBits-1:0]  num;
        logic [QuotBits-1:0] quot;
        logic [DenBits-1:0]  den;
        logic                bad;
    } ubdc_div_t;
endpackage

[src/ubdc_step.sv]
// One registered restoring-division step of the divisor pipeline.
module ubdc_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  ubdc_pkg::ubdc_div_t in_data,
    output logic                out_valid,
    output ubdc_pkg::ubdc_div_t out_data
);
    import ubdc_pkg::*;

    logic              valid_reg;
    ubdc_div_t         data_reg;
    ubdc_div_t         data_next;
    logic [DenBits:0]  trial;
    logic [DenBits:0]  diff;
    logic              ge;

    always_comb begin
        trial = {in_data.rem, in_data.num[NumBits-1]};
        diff  = trial - {1'b0, in_data.den};
        ge    = (trial >= {1'b0, in_data.den});
        data_next      = in_data;
        data_next.rem  = ge ? diff[DenBits-1:0] : trial[DenBits-1:0];
        data_next.num  = {in_data.num[NumBits-2:0], 1'b0};
        data_next.quot = {in_data.quot[QuotBits-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

[src/uart_baud_divisor_calc_core.sv]
// Stages: input reg, mantissa steps, scaling reg, hundredths steps, output reg.
// One beat per cycle unless stalled; 39 one-bit restoring steps are fully pipelined.
// Mantissa is clock/(16*baud); hundredths come from seven more steps on 100x remainder.
// A stall at the output freezes every stage at once.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is not reset.
module uart_baud_divisor_calc_core #(
    parameter int unsigned MANTISSA_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_clock_hz,
    input  logic [31:0] s_baud_rate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_divisor_word,
    output logic        m_status
);
    import ubdc_pkg::*;
    `include "uart_baud_divisor_calc_core_assert.svh"

    localparam int unsigned P1Steps = NumBits;
    localparam int unsigned P2Steps = HundBits;

    logic      en;
    ubdc_div_t in_data_reg;
    logic      in_valid_reg;
    ubdc_div_t mul_data_reg;
    ubdc_div_t mul_data_next;
    logic      mul_valid_reg;
    ubdc_div_t p1_data  [0:P1Steps];
    logic      p1_valid [0:P1Steps];
    ubdc_div_t p2_data  [0:P2Steps];
    logic      p2_valid [0:P2Steps];
    logic [WordBits-1:0] word_reg;
    logic [WordBits-1:0] word_next;
    logic      status_reg;
    logic      status_next;
    logic      out_valid_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            mul_valid_reg <= p1_valid[P1Steps];
            out_valid_reg <= p2_valid[P2Steps];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_data_reg.rem  <= '0;
            in_data_reg.num  <= s_clock_hz;
            in_data_reg.quot <= '0;
            in_data_reg.den  <= {s_baud_rate, 4'b0000};
            in_data_reg.bad  <= (s_clock_hz == '0) || (s_baud_rate == '0);
            mul_data_reg     <= mul_data_next;
            word_reg         <= word_next;
            status_reg       <= status_next;
        end
    end

    assign p1_data[0]  = in_data_reg;
    assign p1_valid[0] = in_valid_reg;

    for (genvar i = 0; i < P1Steps; i++) begin : g_p1
        ubdc_step u_step (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(p1_valid[i]), .in_data(p1_data[i]),
            .out_valid(p1_valid[i+1]), .out_data(p1_data[i+1])
        );
    end

    // Scale the remainder by 100 and feed its top bits as the new partial remainder.
    logic [DenBits+HundBits-1:0] scaled;
    always_comb begin
        scaled = ({{HundBits{1'b0}}, p1_data[P1Steps].rem} << 6)
               + ({{HundBits{1'b0}}, p1_data[P1Steps].rem} << 5)
               + ({{HundBits{1'b0}}, p1_data[P1Steps].rem} << 2);
        mul_data_next      = p1_data[P1Steps];
        mul_data_next.rem  = scaled[DenBits+HundBits-1:HundBits];
        mul_data_next.num  = {scaled[HundBits-1:0], {(NumBits-HundBits){1'b0}}};
    end

    assign p2_data[0]  = mul_data_reg;
    assign p2_valid[0] = mul_valid_reg;

    for (genvar j = 0; j < P2Steps; j++) begin : g_p2
        ubdc_step u_step (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(p2_valid[j]), .in_data(p2_data[j]),
            .out_valid(p2_valid[j+1]), .out_data(p2_data[j+1])
        );
    end

    // Round hundredths to sixteenths, carry into the mantissa, range check.
    logic [NumBits-1:0]  mant;
    logic [HundBits-1:0] hund;
    logic [11:0]         hx;
    logic [4:0]          frac;
    logic [NumBits:0]    mant_c;
    logic [FracBits-1:0] frac_c;
    logic [NumBits+FracBits:0] packed_word;
    always_comb begin
        mant = p2_data[P2Steps].quot[QuotBits-1:HundBits];
        hund = p2_data[P2Steps].quot[HundBits-1:0];
        hx   = {1'b0, hund, 4'b0000} + 12'd50;
        frac = '0;
        for (int k = 1; k <= 16; k++) begin
            if (hx >= 12'(100 * k)) begin
                frac = frac + 5'd1;
            end
        end
        mant_c = {1'b0, mant} + {{NumBits{1'b0}}, frac[4]};
        frac_c = frac[4] ? '0 : frac[3:0];
        packed_word = {mant_c, frac_c};
        if (p2_data[P2Steps].bad || ((mant_c == '0) && (frac_c == '0))
            || ((mant_c >> MANTISSA_BITS) != '0)) begin
            status_next = 1'b1;
            word_next   = '0;
        end else begin
            status_next = 1'b0;
            word_next   = packed_word[WordBits-1:0];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_divisor_word = word_reg;
    assign m_status       = status_reg;

    `UBDC_ASSERT_IMP(a_err_word_zero, m_valid && m_status, m_divisor_word == '0)
    `UBDC_ASSERT_IMP(a_ready_tracks_out, 1'b1, s_ready == (!m_valid || m_ready))
    `UBDC_ASSERT_ALWAYS(a_reset_clears, !aresetn, ##1 (!m_valid && !mul_valid_reg))
endmodule

[test/ubdc_checker.sv]
// Checker for the baud divisor calculator: predicts each result beat and compares it.
module ubdc_checker #(
    parameter int unsigned MANTISSA_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_clock_hz,
    input  logic [31:0] s_baud_rate,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_divisor_word,
    input  logic        m_status,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [15:0] word;
        logic        status;
    } divisor_t;

    divisor_t expected_divisors[$];

    function automatic divisor_t calc_divisor(logic [31:0] clk_hz, logic [31:0] baud);
        logic [63:0] div100, mant, hund, frac, mant_max;
        divisor_t d;
        d = '{word: 16'd0, status: 1'b1};
        if (clk_hz == 0 || baud == 0) return d;
        div100 = (64'(clk_hz) * 64'd25) / (64'(baud) * 64'd4);
        mant = div100 / 64'd100;
        hund = div100 % 64'd100;
        frac = (hund * 64'd16 + 64'd50) / 64'd100;
        if (frac >= 64'd16) begin
            mant = mant + 1;
            frac = 0;
        end
        mant_max = (64'd1 << MANTISSA_BITS) - 1;
        if ((mant == 0 && frac == 0) || mant > mant_max) return d;
        d.word = 16'((mant << 4) | frac);
        d.status = 1'b0;
        return d;
    endfunction

    assign pending = expected_divisors.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        divisor_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_divisors.push_back(calc_divisor(s_clock_hz, s_baud_rate));
            if (m_valid && m_ready) begin
                if (expected_divisors.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat: word=%h status=%0d",
                                 m_divisor_word, m_status);
                end else begin
                    want = expected_divisors.pop_front();
                    if (want.word !== m_divisor_word || want.status !== m_status) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected word=%h status=%0d, got word=%h status=%0d",
                                     want.word, want.status, m_divisor_word, m_status);
                    end
                end
            end
        end
    end
endmodule

[test/tb_top.sv]
// Testbench top: drives clock/baud beats, stalls the result side, reports the verdict.
module tb_top;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_clock_hz = '0;
    logic [31:0] s_baud_rate = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_divisor_word;
    logic        m_status;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 28;
    int          recv_idle_pct = 77;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    uart_baud_divisor_calc_core dut (.*);

    ubdc_checker chk (.*);

    // Receiver stalls at random.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Drive one beat and hold it until accepted.
    task automatic send_beat(logic [31:0] clk_hz, logic [31:0] baud);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_clock_hz <= clk_hz;
        s_baud_rate <= baud;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random pair, mostly in the range that gives a valid divisor.
    task automatic send_random();
        logic [31:0] c, b;
        case ($urandom_range(9))
            0: begin c = $urandom; b = $urandom; end
            1: begin c = $urandom; b = $urandom_range(15); end
            2: begin c = $urandom_range(1000); b = $urandom_range(1000); end
            default: begin
                c = $urandom_range(32'hFFFF_FFFF, 1000);
                // target a mantissa up to about 4600 to straddle the limit
                b = c / (16 * $urandom_range(4600, 1));
                if (b == 0) b = 1;
                b = b + $urandom_range(3) - 1;
            end
        endcase
        send_beat(c, b);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed beats
        send_beat(32'd0, 32'd115200);
        send_beat(32'd50_000_000, 32'd0);
        send_beat(32'd0, 32'd0);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'd1);
        send_beat(32'd1, 32'hFFFF_FFFF);
        send_beat(32'd16_000_000, 32'd115200);
        send_beat(32'd42_000_000, 32'd9600);
        send_beat(32'd84_000_000, 32'd115200);
        send_beat(32'd1600, 32'd100);
        send_beat(32'd16 * 4095, 32'd1);
        send_beat(32'd16 * 4096, 32'd1);
        send_beat(32'd16 * 4095 + 15, 32'd1);
        send_beat(32'd1, 32'd1);
        send_beat(32'd15, 32'd1);
        send_beat(32'd16, 32'd1);
        send_beat(32'd13, 32'd1);
        send_beat(32'd14, 32'd100);
        send_beat(32'hAAAA_AAAA, 32'h5555_5555);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA);
        go_idle();
        // hold off until every expected result is back
        while (pending != 0) @(posedge aclk);
        for (int i = 0; i < 320; i++) send_random();
        send_idle_pct = 77;
        recv_idle_pct = 28;
        for (int i = 0; i < 320; i++) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 310; i++) send_random();
        go_idle();
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("uart_baud_divisor_calc_core regression: pass");
        else
            $display("uart_baud_divisor_calc_core regression: fail");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("uart_baud_divisor_calc_core regression: fail");
        $finish;
    end
endmodule

[uart_baud_divisor_calc_core.f]
+incdir+src
src/ubdc_pkg.sv
src/ubdc_step.sv
src/uart_baud_divisor_calc_core.sv
test/ubdc_checker.sv
test/tb_top.sv
